### rtl/mf_pkg.sv
// Shared types and result codes for the Mobius function block.
// No dependencies; imported by the top level.
package mf_pkg;

  typedef logic signed [1:0] mu_t;

  localparam mu_t MU_PLUS  = 2'sb01;
  localparam mu_t MU_ZERO  = 2'sb00;
  localparam mu_t MU_MINUS = 2'sb11;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_DIV1  = 4'b0100,
    ST_DIV2  = 4'b1000
  } state_t;

endpackage

### rtl/mf_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Standalone; used by mobius_function.
module mf_divider #(
  parameter int NUM_WIDTH = 16,
  parameter int DIV_W     = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NUM_WIDTH-1:0] dividend,
  input  logic [DIV_W-1:0]     divisor,
  output logic                 done,
  output logic [NUM_WIDTH-1:0] quotient,
  output logic [DIV_W-1:0]     remainder
);

  localparam int CNT_W = $clog2(NUM_WIDTH + 1);

  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [NUM_WIDTH-1:0] q_r, q_nxt;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W:0]       trial;
  logic                 fits;

  assign trial = {rem_r, q_r[NUM_WIDTH-1]};
  assign fits  = (trial >= {1'b0, divisor});

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(NUM_WIDTH);
      q_nxt   = dividend;
      rem_nxt = '0;
    end else if (run_r) begin
      // shift in next dividend bit, subtract when it fits
      if (fits) begin
        rem_nxt = DIV_W'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = trial[DIV_W-1:0];
      end
      q_nxt   = {q_r[NUM_WIDTH-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

### rtl/mobius_function.sv
// Mobius function top level: trial-division sequencer around a bit-serial divider.
// Depends on mf_pkg and mf_divider.
//
//   channel  ports                       transfer
//   input    start, busy, in_number      edge with start high and busy low
//   result   out_valid, out_mu           edge ending the cycle out_valid is high
//
// Each candidate divisor d costs a pass through the check state plus one division
// by the bit-serial divider (two divisions when d divides the value); inputs 0
// and 1 finish from the check state without a division. Synchronous active-low
// reset returns the block to idle. The receiver cannot stall: out_valid is a
// one-cycle strobe.
module mobius_function #(
  parameter int NUM_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [NUM_WIDTH-1:0] in_number,
  output logic                 out_valid,
  output mf_pkg::mu_t          out_mu
);

  import mf_pkg::*;

  localparam int D_W  = (NUM_WIDTH + 1) / 2 + 1;
  localparam int SQ_W = NUM_WIDTH + 2;

  state_t               state_r, state_nxt;
  logic [NUM_WIDTH-1:0] rest_r, rest_nxt;
  logic [D_W-1:0]       d_r, d_nxt;
  logic [SQ_W-1:0]      sq_r, sq_nxt;
  logic                 odd_r, odd_nxt;
  logic                 valid_r, valid_nxt;
  mu_t                  mu_r, mu_nxt;

  logic                 div_start;
  logic [NUM_WIDTH-1:0] div_dividend;
  logic                 div_done;
  logic [NUM_WIDTH-1:0] div_quo;
  logic [D_W-1:0]       div_rem;
  logic [SQ_W-1:0]      sq_step;

  mf_divider #(
    .NUM_WIDTH (NUM_WIDTH),
    .DIV_W     (D_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (d_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign sq_step      = sq_r + SQ_W'({d_r, 1'b1});
  assign div_dividend = (state_r == ST_DIV1) ? div_quo : rest_r;

  always_comb begin
    state_nxt = state_r;
    rest_nxt  = rest_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    odd_nxt   = odd_r;
    valid_nxt = 1'b0;
    mu_nxt    = mu_r;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          rest_nxt  = in_number;
          d_nxt     = D_W'(2);
          sq_nxt    = SQ_W'(4);
          odd_nxt   = 1'b0;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sq_r > SQ_W'(rest_r)) begin
          // leftover above one is a last prime factor
          valid_nxt = 1'b1;
          mu_nxt    = (odd_r ^ (rest_r > NUM_WIDTH'(1))) ? MU_MINUS : MU_PLUS;
          state_nxt = ST_IDLE;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (div_done) begin
          if (div_rem == '0) begin
            rest_nxt  = div_quo;
            odd_nxt   = ~odd_r;
            div_start = 1'b1;
            state_nxt = ST_DIV2;
          end else begin
            d_nxt     = d_r + 1'b1;
            sq_nxt    = sq_step;
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_DIV2: begin
        if (div_done) begin
          if (div_rem == '0) begin
            valid_nxt = 1'b1;
            mu_nxt    = MU_ZERO;
            state_nxt = ST_IDLE;
          end else begin
            d_nxt     = d_r + 1'b1;
            sq_nxt    = sq_step;
            state_nxt = ST_CHECK;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rest_r <= rest_nxt;
    d_r    <= d_nxt;
    sq_r   <= sq_nxt;
    odd_r  <= odd_nxt;
    mu_r   <= mu_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = valid_r;
  assign out_mu    = mu_r;

endmodule
